/* hdl/sv39ptm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptm_pkg
// Shared widths, codes and types of the Sv39 page-table mapper.
// ----------------------------------------------------------------------------
package sv39ptm_pkg;

    localparam int VA_W             = 39;
    localparam int PA_W             = 56;
    localparam int PERM_W           = 10;
    localparam int PPN_W            = 44;
    localparam int PTE_W            = 64;
    localparam int STATUS_W         = 3;
    localparam int IDX_W            = 9;
    localparam int ENTRIES_PER_PAGE = 512;
    localparam int TABLE_PAGES_DEF  = 64;

    localparam logic [PPN_W-1:0] BASE_PPN_RESET = 44'd524288;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_MISALIGNED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_PAGES   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_MAPPED     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND  = 3'd4;

    // Write request toward the entry store
    typedef struct packed {
        logic             en;
        logic [PTE_W-1:0] pte;
    } pte_wr_t;

endpackage : sv39ptm_pkg
`default_nettype wire

/* hdl/sv39ptm_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptm_req_if
// Request channel: operation mode, virtual address, physical address, flags.
// ----------------------------------------------------------------------------
interface sv39ptm_req_if import sv39ptm_pkg::*;;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [VA_W-1:0]   va;
    logic [PA_W-1:0]   pa;
    logic [PERM_W-1:0] perm;

    modport source (output valid, output mode, output va, output pa, output perm,
                    input ready);
    modport sink   (input valid, input mode, input va, input pa, input perm,
                    output ready);
endinterface : sv39ptm_req_if
`default_nettype wire

/* hdl/sv39ptm_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptm_rsp_if
// Response channel: status, leaf entry and leaf entry physical address.
// ----------------------------------------------------------------------------
interface sv39ptm_rsp_if import sv39ptm_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PTE_W-1:0]    leaf_entry;
    logic [PA_W-1:0]     leaf_entry_addr;

    modport source (output valid, output status, output leaf_entry,
                    output leaf_entry_addr, input ready);
    modport sink   (input valid, input status, input leaf_entry,
                    input leaf_entry_addr, output ready);
endinterface : sv39ptm_rsp_if
`default_nettype wire

/* hdl/sv39ptm_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptm_store
// Table page memory. Each word carries a mark that tells whether it was
// written after its page was handed out; older words read as zero once the
// page is allocated, which stands in for zeroing a fresh page.
// ----------------------------------------------------------------------------
module sv39ptm_store import sv39ptm_pkg::*;
#(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF
)
(
    input  wire                                      clk,
    input  wire                                      rd_en,
    input  wire  [$clog2(TABLE_PAGES)+IDX_W-1:0]     rd_addr,
    input  wire  [$clog2(TABLE_PAGES)+IDX_W-1:0]     wr_addr,
    input  wire  pte_wr_t                            wr,
    input  wire  [$clog2(TABLE_PAGES+1)-1:0]         alloc_cnt,
    input  wire  [$clog2(TABLE_PAGES+1)-1:0]         wr_alloc_cnt,
    output logic [PTE_W-1:0]                         rd_pte
);

    localparam int PAGE_W = $clog2(TABLE_PAGES);
    localparam int NFP_W  = $clog2(TABLE_PAGES + 1);
    localparam int ADDR_W = PAGE_W + IDX_W;
    localparam int DEPTH  = TABLE_PAGES * ENTRIES_PER_PAGE;

    logic [PTE_W:0]   mem [DEPTH];
    logic [PTE_W:0]   rd_word_reg;
    logic             rd_alloc_reg;
    logic             wr_mark;
    logic             rd_alloc;

    // Page of the written word already handed out (after this cycle's allocation)
    assign wr_mark  = NFP_W'(wr_addr[ADDR_W-1:IDX_W]) < wr_alloc_cnt;
    assign rd_alloc = NFP_W'(rd_addr[ADDR_W-1:IDX_W]) < alloc_cnt;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= {wr_mark, wr.pte};
        end
        if (rd_en)
        begin
            rd_word_reg  <= mem[rd_addr];
            rd_alloc_reg <= rd_alloc;
        end
    end

    // Drop words left over from before the page was allocated
    assign rd_pte = (rd_alloc_reg && !rd_word_reg[PTE_W]) ? '0 : rd_word_reg[PTE_W-1:0];

endmodule : sv39ptm_store
`default_nettype wire

/* hdl/sv39_page_table_mapper_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sv39_page_table_mapper_top
// Three-level Sv39 page-table walker and mapper over an internal table store.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake      | payload
//  ---------+-----------+----------------+-------------------------------------
//  req      | in        | valid / ready  | mode, va, pa, perm
//  rsp      | out       | valid / ready  | status, leaf_entry, leaf_entry_addr
//  cfg      | in        | cfg_we         | cfg_wdata (table_base_ppn)
//
//  A misaligned map goes from accept straight to result hand-off; otherwise
//  each level takes a read state and a check state through the single store read
//  port, between accept and result hand-off. After reset the store is swept
//  clear, word by word, during which req.ready stays low.
//  A finished result waits in the output register; the next transaction is
//  taken while it waits, and the walk stalls only at hand-off if rsp is full.
// ----------------------------------------------------------------------------
module sv39_page_table_mapper_top import sv39ptm_pkg::*;
#(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    sv39ptm_req_if.sink         req,
    sv39ptm_rsp_if.source       rsp,
    input  wire                 cfg_we,
    input  wire  [PPN_W-1:0]    cfg_wdata
);

    localparam int PAGE_W = $clog2(TABLE_PAGES);
    localparam int NFP_W  = $clog2(TABLE_PAGES + 1);
    localparam int ADDR_W = PAGE_W + IDX_W;
    localparam int DEPTH  = TABLE_PAGES * ENTRIES_PER_PAGE;

    localparam logic [NFP_W-1:0]  NFP_LIMIT  = NFP_W'(TABLE_PAGES);
    localparam logic [PPN_W-1:0]  PPN_LIMIT  = PPN_W'(TABLE_PAGES);
    localparam logic [ADDR_W-1:0] CLR_LAST   = ADDR_W'(DEPTH - 1);

    // Sequencer states
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // Control state
    logic [2:0]          state_reg,   state_next;
    logic [1:0]          level_reg,   level_next;
    logic [PAGE_W-1:0]   page_reg,    page_next;
    logic [NFP_W-1:0]    nfp_reg,     nfp_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [PPN_W-1:0]    base_reg;
    logic                out_valid_reg, out_valid_next;

    // Transaction payload
    logic                mode_reg;
    logic [VA_W-1:0]     va_reg;
    logic [PA_W-1:0]     pa_reg;
    logic [PERM_W-1:0]   perm_reg;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [PTE_W-1:0]    res_entry_reg,  res_entry_next;
    logic [PA_W-1:0]     res_addr_reg,   res_addr_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [PTE_W-1:0]    out_entry_reg;
    logic [PA_W-1:0]     out_addr_reg;

    // Datapath
    logic [IDX_W-1:0]    idx;
    logic [ADDR_W-1:0]   slot_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [PTE_W-1:0]    entry;
    logic                entry_valid;
    logic                follow;
    logic [PPN_W-1:0]    add_a, add_b, sum;
    logic                add_sub;
    pte_wr_t             wr;
    logic [NFP_W-1:0]    wr_alloc_cnt;
    logic                req_fire;
    logic                out_load;
    logic                misaligned;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);
    assign misaligned = req.mode && ((req.va[11:0] | req.pa[11:0]) != 12'd0);

    // VPN slice of the current level
    always_comb
    begin
        unique case (level_reg)
            2'd2:    idx = va_reg[38:30];
            2'd1:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    assign slot_addr   = {page_reg, idx};
    assign entry_valid = entry[0];
    assign follow      = (level_reg != 2'd0) && entry_valid;

    // Shared 44-bit adder: pointer PPN minus base when following a valid
    // entry, base plus page for a fresh pointer or the leaf address.
    assign add_sub = follow;
    assign add_a   = follow ? entry[PPN_W+9:10] : base_reg;
    always_comb
    begin
        priority if (level_reg == 2'd0)
            add_b = PPN_W'(page_reg);
        else if (entry_valid)
            add_b = base_reg;
        else
            add_b = PPN_W'(nfp_reg);
    end
    assign sum = add_a + (add_b ^ {PPN_W{add_sub}}) + PPN_W'(add_sub);

    sv39ptm_store #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_store (
        .clk          (clk),
        .rd_en        (state_reg == S_RD),
        .rd_addr      (slot_addr),
        .wr_addr      (wr_addr),
        .wr           (wr),
        .alloc_cnt    (nfp_reg),
        .wr_alloc_cnt (wr_alloc_cnt),
        .rd_pte       (entry)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        level_next      = level_reg;
        page_next       = page_reg;
        nfp_next        = nfp_reg;
        clr_cnt_next    = clr_cnt_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        res_addr_next   = res_addr_reg;
        wr.en           = 1'b0;
        wr.pte          = '0;
        wr_addr         = slot_addr;
        wr_alloc_cnt    = nfp_reg;

        unique case (state_reg)
            S_CLR:
            begin
                // Sweep the store to zero, marked as never written
                wr.en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_alloc_cnt = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_status_next = STAT_OK;
                    res_entry_next  = '0;
                    res_addr_next   = '0;
                    level_next      = 2'd2;
                    page_next       = '0;
                    if (misaligned)
                    begin
                        res_status_next = STAT_MISALIGNED;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (level_reg != 2'd0)
                begin
                    if (entry_valid)
                    begin
                        if (sum < PPN_LIMIT)
                        begin
                            page_next  = sum[PAGE_W-1:0];
                            level_next = level_reg - 2'd1;
                            state_next = S_RD;
                        end
                        else
                        begin
                            res_status_next = STAT_NOT_FOUND;
                            state_next      = S_FIN;
                        end
                    end
                    else if (!mode_reg)
                    begin
                        res_status_next = STAT_NOT_FOUND;
                        state_next      = S_FIN;
                    end
                    else if (nfp_reg >= NFP_LIMIT)
                    begin
                        res_status_next = STAT_NO_PAGES;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        // Allocate a page and link it; a fresh pointer resolves back to the
                        // page just taken as long as the base PPN stays unchanged.
                        nfp_next     = nfp_reg + NFP_W'(1);
                        wr_alloc_cnt = nfp_next;
                        wr.en        = 1'b1;
                        wr.pte       = {10'd0, sum, 10'd1};
                        page_next    = nfp_reg[PAGE_W-1:0];
                        level_next   = level_reg - 2'd1;
                        state_next   = S_RD;
                    end
                end
                else
                begin
                    res_addr_next = {sum, idx, 3'd0};
                    res_entry_next = entry;
                    state_next     = S_FIN;
                    if (mode_reg)
                    begin
                        if (entry_valid)
                        begin
                            res_status_next = STAT_MAPPED;
                        end
                        else
                        begin
                            wr.en          = 1'b1;
                            wr.pte         = {10'd0, pa_reg[PA_W-1:12], 10'd0} |
                                             PTE_W'(perm_reg) | PTE_W'(1);
                            res_entry_next = wr.pte;
                        end
                    end
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load a finished result, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            level_reg     <= 2'd0;
            page_reg      <= '0;
            nfp_reg       <= NFP_W'(1);
            clr_cnt_reg   <= '0;
            base_reg      <= BASE_PPN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            page_reg      <= page_next;
            nfp_reg       <= nfp_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            mode_reg <= req.mode;
            va_reg   <= req.va;
            pa_reg   <= req.pa;
            perm_reg <= req.perm;
        end
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        res_addr_reg   <= res_addr_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
            out_addr_reg   <= res_addr_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.leaf_entry      = out_entry_reg;
    assign rsp.leaf_entry_addr = out_addr_reg;

`ifndef SYNTHESIS
    // Allocator never runs past the store
    a_nfp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nfp_reg <= NFP_LIMIT)
        else $error("allocator passed the page limit");

    // Allocation only happens while checking an upper entry
    a_nfp_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(nfp_reg) |-> ($past(state_reg) == S_CHK) && ($past(level_reg) != 2'd0))
        else $error("page allocated outside an upper-level check");

    // A result appears only from the hand-off state
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result shown without a finished walk");

    // No request is taken during the clearing sweep
    a_no_req_clr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |=> !$past(req.ready))
        else $error("request accepted while clearing");
`endif

endmodule : sv39_page_table_mapper_top
`default_nettype wire

/* tb/tb_sv39_page_table_mapper_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sv39_page_table_mapper_top
// Self-checking bench for the Sv39 page-table mapper. It keeps its own image
// of the table store, the page allocator and the base PPN. It predicts every
// lookup and map transaction when the transaction is accepted, and it checks
// each response field against the oldest prediction. The run moves through
// several base PPN settings, exhausts the table pages and applies
// backpressure on both channels.
// ----------------------------------------------------------------------------
module tb_sv39_page_table_mapper_top import sv39ptm_pkg::*;;

    localparam int PAGES       = TABLE_PAGES_DEF;
    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 9;
    localparam int CYCLE_LIMIT = 600000;   // clear sweep plus several times the slowest run
    localparam int IDLE_PCT    = 23;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;

    localparam logic             MODE_LOOKUP = 1'b0;
    localparam logic             MODE_MAP    = 1'b1;
    localparam logic [PPN_W-1:0] PPN_MAX     = '1;

    typedef struct packed {
        logic              mode;
        logic [VA_W-1:0]   va;
        logic [PA_W-1:0]   pa;
        logic [PERM_W-1:0] perm;
    } map_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PTE_W-1:0]    leaf_entry;
        logic [PA_W-1:0]     leaf_entry_addr;
    } leaf_rsp_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [PPN_W-1:0] cfg_wdata;

    sv39ptm_req_if req_ch ();
    sv39ptm_rsp_if rsp_ch ();

    sv39_page_table_mapper_top #(
        .TABLE_PAGES (PAGES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Bench copy of the block state: table store, bump allocator, base PPN
    bit   [PTE_W-1:0] pt_image [PAGES*ENTRIES_PER_PAGE];
    int unsigned      next_page = 1;
    logic [PPN_W-1:0] base_ppn  = BASE_PPN_RESET;

    map_req_t    req_backlog [$];   // transactions waiting for the driver
    leaf_rsp_t   leaf_rsp_q  [$];   // predicted responses, oldest first
    logic [17:0] prefix_pool [$];   // va[38:21] of issued maps
    logic [26:0] mapped_vpn  [$];   // va[38:12] of issued maps
    map_req_t    on_wire;

    int unsigned err_cnt     = 0;
    int unsigned rsp_cnt     = 0;
    int unsigned cycle_cnt   = 0;
    int unsigned base_writes = 0;
    int unsigned stat_cnt [5];
    int unsigned stall_left  = 0;
    bit          stall_done  = 1'b0;
    bit          stall_arm   = 1'b0;
    bit          steady      = 1'b0;

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Walk the three levels in the bench image, allocating on maps, and
    // return the response that the block must give for this transaction.
    function automatic leaf_rsp_t walk_and_map(input map_req_t rq);
        leaf_rsp_t        r;
        int unsigned      page;
        int unsigned      slot;
        logic [PPN_W-1:0] rel;
        logic [PPN_W-1:0] ppn;
        r    = '0;
        page = 0;
        if (rq.mode == MODE_MAP && (rq.va[11:0] | rq.pa[11:0]) != '0)
        begin
            r.status = STAT_MISALIGNED;
            return r;
        end
        for (int lvl = 2; lvl > 0; lvl--)
        begin
            slot = page * ENTRIES_PER_PAGE + rq.va[12 + 9*lvl +: 9];
            if (!pt_image[slot][0])
            begin
                if (rq.mode == MODE_LOOKUP)
                begin
                    r.status = STAT_NOT_FOUND;
                    return r;
                end
                if (next_page >= PAGES)
                begin
                    r.status = STAT_NO_PAGES;
                    return r;
                end
                // Hand out a zeroed page and link it in
                for (int e = 0; e < ENTRIES_PER_PAGE; e++)
                begin
                    pt_image[next_page * ENTRIES_PER_PAGE + e] = '0;
                end
                ppn            = base_ppn + PPN_W'(next_page);
                pt_image[slot] = {10'd0, ppn, 10'd1};
                next_page++;
            end
            // Follow the pointer relative to the current base; drop out if it
            // lands outside the store
            rel = pt_image[slot][PPN_W+9:10] - base_ppn;
            if (rel >= PAGES)
            begin
                r.status = STAT_NOT_FOUND;
                return r;
            end
            page = rel[15:0];
        end
        slot              = page * ENTRIES_PER_PAGE + rq.va[20:12];
        ppn               = base_ppn + PPN_W'(page);
        r.leaf_entry_addr = {ppn, rq.va[20:12], 3'd0};
        if (rq.mode == MODE_MAP)
        begin
            if (pt_image[slot][0])
            begin
                r.status     = STAT_MAPPED;
                r.leaf_entry = pt_image[slot];
                return r;
            end
            pt_image[slot] = {10'd0, rq.pa[PA_W-1:12], rq.perm | 10'd1};
        end
        r.status     = STAT_OK;
        r.leaf_entry = pt_image[slot];
        return r;
    endfunction

    function automatic logic [VA_W-1:0] va_of(input int vpn2, input int vpn1,
                                              input int vpn0, input int offs);
        return {9'(vpn2), 9'(vpn1), 9'(vpn0), 12'(offs)};
    endfunction

    // Queue one transaction; remember the walk path of aligned maps so that
    // later traffic can reuse it
    task automatic push_req(input logic m, input logic [VA_W-1:0] va,
                            input logic [PA_W-1:0] pa, input logic [PERM_W-1:0] perm);
        if (m == MODE_MAP && va[11:0] == '0 && pa[11:0] == '0)
        begin
            prefix_pool.push_back(va[38:21]);
            mapped_vpn.push_back(va[38:12]);
        end
        req_backlog.push_back('{m, va, pa, perm});
    endtask

    // Random traffic: mostly walks over paths already built, some partly new
    // paths, some fully random addresses and a few misaligned maps
    task automatic push_random(input int n);
        map_req_t    rq;
        int unsigned pick;
        repeat (n)
        begin
            pick    = $urandom_range(99);
            rq.mode = 1'($urandom_range(1));
            rq.va   = VA_W'({$urandom(), $urandom()});
            rq.pa   = PA_W'({$urandom(), $urandom()});
            rq.perm = PERM_W'($urandom());
            if (pick < 60 && prefix_pool.size() != 0)
                rq.va[38:21] = prefix_pool[$urandom_range(prefix_pool.size() - 1)];
            else if (pick < 80 && mapped_vpn.size() != 0)
                rq.va[38:12] = mapped_vpn[$urandom_range(mapped_vpn.size() - 1)];
            else if (pick < 88 && prefix_pool.size() != 0)
                rq.va[38:30] = prefix_pool[$urandom_range(prefix_pool.size() - 1)][17:9];
            if (rq.mode == MODE_MAP && $urandom_range(99) >= 8)
            begin
                rq.va[11:0] = '0;
                rq.pa[11:0] = '0;
            end
            push_req(rq.mode, rq.va, rq.pa, rq.perm);
        end
    endtask

    // Maps on fresh upper-level slots until the allocator runs dry
    task automatic push_exhaust(input int n);
        for (int k = 0; k < n; k++)
        begin
            push_req(MODE_MAP, va_of(384 + k, $urandom_range(511), $urandom_range(511), 0),
                     {44'({$urandom(), $urandom()}), 12'd0}, PERM_W'($urandom()));
        end
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || req_ch.valid || leaf_rsp_q.size() != 0)
            @(negedge clk);
    endtask

    // Write the base PPN while the block is idle and track it in the image
    task automatic write_base(input logic [PPN_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        base_ppn  = v;
        base_writes++;
    endtask

    task automatic check_leaf_rsp();
        leaf_rsp_t want;
        rsp_cnt++;
        if (leaf_rsp_q.size() == 0)
        begin
            err_cnt++;
            $display("%0t: unexpected response status %0d entry %h addr %h", $time,
                     rsp_ch.status, rsp_ch.leaf_entry, rsp_ch.leaf_entry_addr);
            return;
        end
        want = leaf_rsp_q.pop_front();
        stat_cnt[want.status]++;
        if (rsp_ch.status !== want.status)
        begin
            err_cnt++;
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, rsp_ch.status);
        end
        if (rsp_ch.leaf_entry !== want.leaf_entry)
        begin
            err_cnt++;
            $display("%0t: leaf_entry expected %h actual %h", $time,
                     want.leaf_entry, rsp_ch.leaf_entry);
        end
        if (rsp_ch.leaf_entry_addr !== want.leaf_entry_addr)
        begin
            err_cnt++;
            $display("%0t: leaf_entry_addr expected %h actual %h", $time,
                     want.leaf_entry_addr, rsp_ch.leaf_entry_addr);
        end
    endtask

    // Request driver: predict on acceptance, then offer the next transaction
    // or idle at random; hold the payload while the block stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.mode  <= MODE_LOOKUP;
            req_ch.va    <= '0;
            req_ch.pa    <= '0;
            req_ch.perm  <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                leaf_rsp_q.push_back(walk_and_map(on_wire));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    on_wire      = req_backlog.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.mode  <= on_wire.mode;
                    req_ch.va    <= on_wire.va;
                    req_ch.pa    <= on_wire.pa;
                    req_ch.perm  <= on_wire.perm;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: check each accepted response, then pick the ready
    // level for the next cycle; once armed, hold ready low for a long stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                check_leaf_rsp();
            if (stall_arm && !stall_done)
            begin
                stall_left = HOLD_CYCLES;
                stall_done = 1'b1;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d responses outstanding",
                     cycle_cnt, leaf_rsp_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned mark;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = BASE_PPN_RESET;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty root, misalignment on either address, first map,
        // remap, lookups that stop at each level, extreme addresses and flags.
        // The block is still sweeping its store; the driver just waits on ready.
        push_req(MODE_LOOKUP, '0, '0, '0);
        push_req(MODE_MAP, va_of(1, 2, 3, 12'h123), 56'h1234_5000, 10'h0);
        push_req(MODE_MAP, va_of(1, 2, 3, 0), 56'h0ABC, 10'h0);
        push_req(MODE_MAP, va_of(1, 2, 3, 0), 56'h1234_5000, 10'h0);
        push_req(MODE_MAP, va_of(1, 2, 3, 0), 56'h9876_5000, 10'h3FF);
        push_req(MODE_LOOKUP, va_of(1, 2, 3, 12'hFFF), '1, 10'h3FF);
        push_req(MODE_LOOKUP, va_of(1, 2, 4, 0), '0, '0);
        push_req(MODE_LOOKUP, va_of(1, 5, 0, 0), '0, '0);
        push_req(MODE_MAP, {27'h7FF_FFFF, 12'd0}, {44'hFFF_FFFF_FFFF, 12'd0}, 10'h3FF);
        push_req(MODE_LOOKUP, '1, '1, '1);
        push_req(MODE_MAP, '0, '0, '0);
        push_req(MODE_LOOKUP, '0, '0, '0);
        push_req(MODE_MAP, '0, '0, '0);
        push_req(MODE_MAP, va_of(1, 5, 0, 0), 56'hA5_5A5A_5A5A_5000, 10'h2AA);
        push_req(MODE_MAP, va_of(1, 2, 511, 0), 56'h5A_A5A5_A5A5_A000, 10'h155);
        push_req(MODE_LOOKUP, va_of(1, 2, 511, 12'h800), 56'h0ABC, '0);
        push_req(MODE_MAP, {27'h7FF_FFFF, 12'd0}, 56'h0000_0000_0001_000, 10'h001);
        push_random(230);
        wait_drained();

        // Lowest base: every pointer built so far now lands outside the store
        write_base('0);
        push_random(150);
        wait_drained();

        // Highest base: new pointers wrap, old ones shift by one page
        write_base(PPN_MAX);
        push_random(150);
        wait_drained();

        // One page above the reset base, with no idling on either side, and
        // drive the allocator to exhaustion
        steady = 1'b1;
        write_base(BASE_PPN_RESET + 1);
        push_random(150);
        push_exhaust(40);
        wait_drained();
        steady = 1'b0;

        // Back to the reset base; stall the response side mid-stream so the
        // block fills up and pushes back on requests
        write_base(BASE_PPN_RESET);
        mark = rsp_cnt + 60;
        push_random(760);
        while (rsp_cnt < mark) @(negedge clk);
        stall_arm = 1'b1;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d transactions over %0d base settings; %0d of %0d table pages used.",
                 rsp_cnt, base_writes + 1, next_page, PAGES);
        $display("Outcomes: ok %0d, misaligned %0d, out of pages %0d, mapped %0d, not found %0d.",
                 stat_cnt[STAT_OK], stat_cnt[STAT_MISALIGNED], stat_cnt[STAT_NO_PAGES],
                 stat_cnt[STAT_MAPPED], stat_cnt[STAT_NOT_FOUND]);
        if (err_cnt == 0 && leaf_rsp_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule : tb_sv39_page_table_mapper_top

/* files.f */
hdl/sv39ptm_pkg.sv
hdl/sv39ptm_req_if.sv
hdl/sv39ptm_rsp_if.sv
hdl/sv39ptm_store.sv
hdl/sv39_page_table_mapper_top.sv
tb/tb_sv39_page_table_mapper_top.sv
